// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define SBBF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Checked at every edge, reset included.
`define SBBF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/sbbf_pkg.sv
// ----------------------------------------------------------------------------
// Split-block Bloom filter package
// Sizes, salts, action codes and the probe mask function.
// ----------------------------------------------------------------------------
package sbbf_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int PROBES     = 8;
    localparam int WORD_W     = 32;
    localparam int ROW_W      = PROBES * WORD_W;
    localparam int ROW_AW     = $clog2(MAX_BLOCKS);
    localparam int WORD_SEL_W = $clog2(PROBES);
    localparam int WORD_AW    = 13;
    localparam int HASH_W     = 64;
    localparam int HALF_W     = 32;
    localparam int CFG_W      = 11;
    localparam int CFG_RESET  = 1024;
    localparam int SALT_SHIFT = 32 - 5;

    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = HALF_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam logic [WORD_W-1:0] SALTS [PROBES] = '{
        32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
        32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
    };

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_TEST   = 2'd1,
        ACT_WRITE  = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    // One bit per word of a block: the top bits of seed times the word's salt.
    function automatic logic [ROW_W-1:0] probe_mask(input logic [HALF_W-1:0] seed);
        logic [ROW_W-1:0]  mask;
        logic [WORD_W-1:0] prod;
        mask = '0;
        for (int p = 0; p < PROBES; p++) begin
            prod = seed * SALTS[p];
            mask[p * WORD_W + int'(prod[WORD_W-1:SALT_SHIFT])] = 1'b1;
        end
        return mask;
    endfunction

endpackage

// File: design/sbbf_in_if.sv
// ----------------------------------------------------------------------------
// Filter request channel
// Carries one action with its key hash or word address and data.
// ----------------------------------------------------------------------------
interface sbbf_in_if;
    import sbbf_pkg::*;

    logic                valid;
    logic                ready;
    t_action             action;
    logic [HASH_W-1:0]   key_hash;
    logic [WORD_AW-1:0]  word_index;
    logic [WORD_W-1:0]   word_data;

    modport source (output valid, action, key_hash, word_index, word_data, input ready);
    modport sink   (input valid, action, key_hash, word_index, word_data, output ready);
    modport mon    (input valid, ready, action, key_hash, word_index, word_data);
endinterface

// File: design/sbbf_out_if.sv
// ----------------------------------------------------------------------------
// Filter result channel
// Carries the test result and the word read back.
// ----------------------------------------------------------------------------
interface sbbf_out_if;
    import sbbf_pkg::*;

    logic               valid;
    logic               ready;
    logic               maybe_present;
    logic [WORD_W-1:0]  word_out;

    modport source (output valid, maybe_present, word_out, input ready);
    modport sink   (input valid, maybe_present, word_out, output ready);
    modport mon    (input valid, ready, maybe_present, word_out);
endinterface

// File: design/sbbf_cfg_if.sv
// ----------------------------------------------------------------------------
// Filter configuration channel
// Carries writes of the block count register.
// ----------------------------------------------------------------------------
interface sbbf_cfg_if;
    import sbbf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CFG_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: design/sbbf_ram.sv
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sbbf_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: design/sbbf_divider.sv
// ----------------------------------------------------------------------------
// Block index remainder unit
// Restoring remainder of the upper hash half by the block count,
// a few quotient bits per cycle.
// ----------------------------------------------------------------------------
module sbbf_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sbbf_pkg::HALF_W-1:0] i_dividend,
    input  logic [sbbf_pkg::CFG_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [sbbf_pkg::CFG_W-1:0]  o_rem
);
    import sbbf_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [HALF_W-1:0]     r_dvd;
    logic [CFG_W-1:0]      r_rem;
    logic [CFG_W-1:0]      r_divisor;
    logic [HALF_W-1:0]     n_dvd;
    logic [CFG_W-1:0]      n_rem;

    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        for (int s = 0; s < DIV_STEPS; s++) begin
            n_rem = {n_rem[CFG_W-2:0], n_dvd[HALF_W-1]};
            n_dvd = {n_dvd[HALF_W-2:0], 1'b0};
            if (n_rem >= r_divisor) begin
                n_rem = n_rem - r_divisor;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_cnt     <= '0;
                r_dvd     <= i_dividend;
                r_rem     <= '0;
                r_divisor <= i_divisor;
            end else if (r_busy) begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// File: design/split_block_bloom_filter.sv
// ----------------------------------------------------------------------------
// Split-block Bloom filter
// Insert, test, word write and word read over a store of 256-bit blocks.
// ----------------------------------------------------------------------------
// The filter handles one request at a time. An insert or test passes through
// these steps in order: take the request, run the remainder unit that reduces
// the upper hash half modulo the block count at four bits per cycle, read the
// block, write it back for an insert, and register the result. A word write or
// read takes the request and starts the block read, writes the block back for a
// write, and registers the result. A result waiting in the output register
// stalls only the next request's final step. After reset the store is cleared
// one block per cycle over all 1024 blocks, during which no request transfer
// takes place; configuration writes are taken then.
// ----------------------------------------------------------------------------
module split_block_bloom_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbbf_in_if.sink    i_in,
    sbbf_out_if.source o_out,
    sbbf_cfg_if.sink   i_cfg
);
    import sbbf_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_READ,
        S_RESP
    } t_state;

    t_state                r_state;
    logic [ROW_AW-1:0]     r_clr_addr;
    logic [CFG_W-1:0]      r_block_count;
    t_action               r_action;
    logic [ROW_W-1:0]      r_mask;
    logic [WORD_AW-1:0]    r_word_index;
    logic [WORD_W-1:0]     r_word_data;
    logic [ROW_AW-1:0]     r_row;
    logic                  r_present;
    logic [WORD_W-1:0]     r_word;
    logic                  r_out_valid;
    logic                  r_out_present;
    logic [WORD_W-1:0]     r_out_word;

    logic                  w_in_fire;
    logic                  w_is_hash;
    logic [CFG_W-1:0]      w_eff_blocks;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [CFG_W-1:0]      w_div_rem;
    logic                  w_rd_en;
    logic [ROW_AW-1:0]     w_rd_addr;
    logic [ROW_W-1:0]      w_rd_data;
    logic                  w_wr_en;
    logic [ROW_AW-1:0]     w_wr_addr;
    logic [ROW_W-1:0]      w_wr_data;
    logic [ROW_W-1:0]      n_row;
    logic [WORD_W-1:0]     w_sel_word;
    logic                  w_out_free;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_fire   = i_in.valid && (r_state == S_IDLE);
    assign w_is_hash   = (i_in.action == ACT_INSERT) || (i_in.action == ACT_TEST);
    assign w_out_free  = !r_out_valid || o_out.ready;

    always_comb begin
        if (r_block_count == '0) begin
            w_eff_blocks = CFG_W'(1);
        end else if (r_block_count > CFG_W'(MAX_BLOCKS)) begin
            w_eff_blocks = CFG_W'(MAX_BLOCKS);
        end else begin
            w_eff_blocks = r_block_count;
        end
    end

    assign w_div_start = w_in_fire && w_is_hash;

    sbbf_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_in.key_hash[HASH_W-1:HALF_W]),
        .i_divisor  (w_eff_blocks),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    assign w_rd_en   = (w_in_fire && !w_is_hash) || ((r_state == S_DIV) && w_div_done);
    assign w_rd_addr = (r_state == S_IDLE) ? i_in.word_index[WORD_AW-1:WORD_SEL_W]
                                           : w_div_rem[ROW_AW-1:0];

    assign w_sel_word = w_rd_data[r_word_index[WORD_SEL_W-1:0] * WORD_W +: WORD_W];

    always_comb begin
        n_row = w_rd_data;
        case (r_action)
            ACT_INSERT: n_row = w_rd_data | r_mask;
            ACT_WRITE:  n_row[r_word_index[WORD_SEL_W-1:0] * WORD_W +: WORD_W] = r_word_data;
            default:    n_row = w_rd_data;
        endcase
    end

    assign w_wr_en   = (r_state == S_CLEAR) ||
                       ((r_state == S_READ) &&
                        ((r_action == ACT_INSERT) || (r_action == ACT_WRITE)));
    assign w_wr_addr = (r_state == S_CLEAR) ? r_clr_addr : r_row;
    assign w_wr_data = (r_state == S_CLEAR) ? '0 : n_row;

    sbbf_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (ROW_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_block_count <= CFG_W'(CFG_RESET);
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_block_count <= i_cfg.data;
            end
            if (o_out.ready && !((r_state == S_RESP) && w_out_free)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ROW_AW'(MAX_BLOCKS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_action     <= i_in.action;
                        r_mask       <= probe_mask(i_in.key_hash[HALF_W-1:0]);
                        r_word_index <= i_in.word_index;
                        r_word_data  <= i_in.word_data;
                        r_row        <= i_in.word_index[WORD_AW-1:WORD_SEL_W];
                        r_state      <= w_is_hash ? S_DIV : S_READ;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_row   <= w_div_rem[ROW_AW-1:0];
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_present <= (r_action == ACT_TEST) && ((w_rd_data & r_mask) == r_mask);
                    r_word    <= (r_action == ACT_READ) ? w_sel_word : '0;
                    r_state   <= S_RESP;
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_present <= r_present;
                        r_out_word    <= r_word;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.maybe_present = r_out_present;
    assign o_out.word_out      = r_out_word;
endmodule

// File: design/sbbf_checker.sv
// ----------------------------------------------------------------------------
// Split-block Bloom filter checker
// Port-level assertions on request and result transfers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbbf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    sbbf_in_if.sink    i_in,
    sbbf_out_if.source o_out
);
    import sbbf_pkg::*;

    logic                w_out_stall;
    logic                w_in_fire;
    logic                w_out_word;
    logic [WORD_W:0]     w_out_payload;

    assign w_out_stall   = o_out.valid && !o_out.ready;
    assign w_in_fire     = i_in.valid && i_in.ready;
    assign w_out_word    = o_out.valid && (o_out.word_out != '0);
    assign w_out_payload = {o_out.maybe_present, o_out.word_out};

    `SBBF_ASSERT(a_out_hold, i_clk, i_rst_n,
        w_out_stall |=> o_out.valid && $stable(w_out_payload), "stalled result changed")
    `SBBF_ASSERT(a_one_at_a_time, i_clk, i_rst_n,
        w_in_fire |=> !i_in.ready, "request taken while busy")
    `SBBF_ASSERT(a_result_kind, i_clk, i_rst_n,
        w_out_word |-> !o_out.maybe_present, "result carries both word and test bit")
    `SBBF_ASSERT_ALWAYS(a_clear_after_reset, i_clk,
        !i_rst_n |=> !i_in.ready, "request accepted before store clear")
endmodule

bind split_block_bloom_filter sbbf_checker u_sbbf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);
